[hdl/tbs_pkg.sv]
package tbs_pkg;

  localparam int unsigned CORNER_W   = 16;
  localparam int unsigned LOCAL_W    = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Limit widths cover the full parameter ranges of the block.
  localparam int unsigned SRC_LIM_W = 17;
  localparam int unsigned VTX_LIM_W = 13;
  localparam int unsigned IDX_LIM_W = 14;

  localparam logic [15:0] SRC_COUNT_RST = 16'd65535;
  localparam logic [10:0] MAX_VTX_RST   = 11'd1024;
  localparam logic [11:0] MAX_IDX_RST   = 12'd3072;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_COUNT = 2'd0,
    CFG_MAX_VERTICES = 2'd1,
    CFG_MAX_INDICES  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
    logic                last_triangle;
  } in_t;

  typedef struct packed {
    logic                starts_new_batch;
    logic [LOCAL_W-1:0]  local_a;
    logic [LOCAL_W-1:0]  local_b;
    logic [LOCAL_W-1:0]  local_c;
    logic [1:0]          appended_count;
    logic [CORNER_W-1:0] appended_first;
    logic [CORNER_W-1:0] appended_second;
    logic [CORNER_W-1:0] appended_third;
    logic                error_flag;
    logic                mesh_end;
  } out_t;

  // Effective limits after capping and clamping.
  typedef struct packed {
    logic [SRC_LIM_W-1:0] src_lim;
    logic [VTX_LIM_W-1:0] vtx_lim;
    logic [IDX_LIM_W-1:0] idx_lim;
  } lim_t;

endpackage

[hdl/tbs_ram.sv]
module tbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tbs_cfg.sv]
module tbs_cfg #(
  parameter int unsigned SOURCE_VERTICES = 65536,
  parameter int unsigned BATCH_VERTICES  = 1024,
  parameter int unsigned BATCH_INDICES   = 3072
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tbs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tbs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output tbs_pkg::lim_t                   lim_o
);

  localparam logic [tbs_pkg::SRC_LIM_W-1:0] SrcCap = tbs_pkg::SRC_LIM_W'(SOURCE_VERTICES);
  localparam logic [tbs_pkg::VTX_LIM_W-1:0] VtxCap = tbs_pkg::VTX_LIM_W'(BATCH_VERTICES);
  localparam logic [tbs_pkg::IDX_LIM_W-1:0] IdxCap = tbs_pkg::IDX_LIM_W'(BATCH_INDICES);

  logic [15:0] src_count_q;
  logic [10:0] max_vtx_q;
  logic [11:0] max_idx_q;

  logic [tbs_pkg::SRC_LIM_W-1:0] src_ext;
  logic [tbs_pkg::VTX_LIM_W-1:0] vtx_ext;
  logic [tbs_pkg::IDX_LIM_W-1:0] idx_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_count_q <= tbs_pkg::SRC_COUNT_RST;
      max_vtx_q   <= tbs_pkg::MAX_VTX_RST;
      max_idx_q   <= tbs_pkg::MAX_IDX_RST;
    end else if (cfg_we_i) begin
      case (tbs_pkg::cfg_idx_e'(cfg_index_i))
        tbs_pkg::CFG_SOURCE_COUNT: src_count_q <= cfg_data_i;
        tbs_pkg::CFG_MAX_VERTICES: max_vtx_q   <= cfg_data_i[10:0];
        tbs_pkg::CFG_MAX_INDICES:  max_idx_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    src_ext = tbs_pkg::SRC_LIM_W'(src_count_q);
    vtx_ext = tbs_pkg::VTX_LIM_W'(max_vtx_q);
    idx_ext = tbs_pkg::IDX_LIM_W'(max_idx_q);

    lim_o.src_lim = (src_ext > SrcCap) ? SrcCap : src_ext;

    if (vtx_ext < tbs_pkg::VTX_LIM_W'(3)) begin
      lim_o.vtx_lim = tbs_pkg::VTX_LIM_W'(3);
    end else if (vtx_ext > VtxCap) begin
      lim_o.vtx_lim = VtxCap;
    end else begin
      lim_o.vtx_lim = vtx_ext;
    end

    if (idx_ext < tbs_pkg::IDX_LIM_W'(3)) begin
      lim_o.idx_lim = tbs_pkg::IDX_LIM_W'(3);
    end else if (idx_ext > IdxCap) begin
      lim_o.idx_lim = IdxCap;
    end else begin
      lim_o.idx_lim = idx_ext;
    end
  end

endmodule

[hdl/tbs_seq.sv]
module tbs_seq #(
  parameter int unsigned SOURCE_VERTICES = 65536,
  parameter int unsigned BATCH_VERTICES  = 1024,
  parameter int unsigned BATCH_INDICES   = 3072
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tbs_pkg::lim_t  lim_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tbs_pkg::in_t   in_data_i,
  output logic           emit_valid_o,
  input  logic           emit_ready_i,
  output tbs_pkg::out_t  emit_data_o
);

  localparam int unsigned AW  = $clog2(SOURCE_VERTICES);
  localparam int unsigned LW  = $clog2(BATCH_VERTICES);
  localparam int unsigned VCW = $clog2(BATCH_VERTICES + 1);
  localparam int unsigned ICW = $clog2(BATCH_INDICES + 1);
  localparam int unsigned DW  = LW + 1;
  localparam logic [AW-1:0] InitLast = AW'(SOURCE_VERTICES - 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_CLEAR,
    S_APPEND,
    S_EMIT
  } state_e;

  state_e              state_q;
  tbs_pkg::in_t        item_q;
  tbs_pkg::out_t       res_q;
  tbs_pkg::out_t       res_init;
  logic [1:0]          k_q;
  logic [2:0]          look_v_q;
  logic [LW-1:0]       look_l_q [3];
  logic [VCW-1:0]      vcnt_q;
  logic [ICW-1:0]      icnt_q;
  logic                err_q;
  logic [VCW-1:0]      clr_q;
  logic                pend_q;
  logic                fin_q;
  logic [AW-1:0]       init_q;

  // remap RAM ports
  logic                map_we;
  logic [AW-1:0]       map_waddr;
  logic [DW-1:0]       map_wdata;
  logic                map_re;
  logic [AW-1:0]       map_raddr;
  logic [DW-1:0]       map_rdata;

  // touched list RAM ports
  logic                tl_we;
  logic [LW-1:0]       tl_waddr;
  logic                tl_re;
  logic [LW-1:0]       tl_raddr;
  logic [AW-1:0]       tl_rdata;

  logic [tbs_pkg::CORNER_W-1:0] cur_corner;
  logic [2:0]          dup;
  logic [2:0]          is_new;
  logic [1:0]          extra;
  logic                need_close;
  logic                in_bad;
  logic                clr_rd;
  logic                cur_dup;
  logic                cur_valid;
  logic [LW-1:0]       cur_look;
  logic [tbs_pkg::LOCAL_W-1:0] cur_local;
  logic [tbs_pkg::LOCAL_W-1:0] dup_local;
  logic [VCW:0]        vtx_sum;
  logic [ICW:0]        idx_sum;

  function automatic logic [tbs_pkg::CORNER_W-1:0] pick_corner(tbs_pkg::in_t t,
                                                               logic [1:0] k);
    logic [tbs_pkg::CORNER_W-1:0] c;
    case (k)
      2'd0:    c = t.corner_a;
      2'd1:    c = t.corner_b;
      default: c = t.corner_c;
    endcase
    return c;
  endfunction

  assign in_bad = ({1'b0, in_data_i.corner_a} >= lim_i.src_lim)
               || ({1'b0, in_data_i.corner_b} >= lim_i.src_lim)
               || ({1'b0, in_data_i.corner_c} >= lim_i.src_lim);

  always_comb begin
    res_init            = '0;
    res_init.mesh_end   = in_data_i.last_triangle;
    res_init.error_flag = in_bad;
  end

  // a corner repeated inside the triangle is counted at its first occurrence
  assign dup[0] = 1'b0;
  assign dup[1] = (item_q.corner_b == item_q.corner_a);
  assign dup[2] = (item_q.corner_c == item_q.corner_a) || (item_q.corner_c == item_q.corner_b);
  assign is_new = ~dup & ~look_v_q;
  assign extra  = {1'b0, is_new[0]} + {1'b0, is_new[1]} + {1'b0, is_new[2]};

  assign vtx_sum = {1'b0, vcnt_q} + (VCW + 1)'(extra);
  assign idx_sum = {1'b0, icnt_q} + (ICW + 1)'(3);
  assign need_close = (icnt_q != '0)
                   && ((idx_sum > (ICW + 1)'(lim_i.idx_lim))
                    || (vtx_sum > (VCW + 1)'(lim_i.vtx_lim)));

  assign cur_corner = pick_corner(item_q, k_q);
  assign clr_rd     = (clr_q < vcnt_q);

  always_comb begin
    case (k_q)
      2'd0: begin
        cur_dup   = dup[0];
        cur_valid = look_v_q[0];
        cur_look  = look_l_q[0];
        dup_local = res_q.local_a;
      end
      2'd1: begin
        cur_dup   = dup[1];
        cur_valid = look_v_q[1];
        cur_look  = look_l_q[1];
        dup_local = res_q.local_a;
      end
      default: begin
        cur_dup   = dup[2];
        cur_valid = look_v_q[2];
        cur_look  = look_l_q[2];
        dup_local = (item_q.corner_c == item_q.corner_a) ? res_q.local_a : res_q.local_b;
      end
    endcase
    if (cur_dup) begin
      cur_local = dup_local;
    end else if (cur_valid) begin
      cur_local = tbs_pkg::LOCAL_W'(cur_look);
    end else begin
      cur_local = tbs_pkg::LOCAL_W'(LW'(vcnt_q));
    end
  end

  always_comb begin
    map_we    = 1'b0;
    map_waddr = AW'(cur_corner);
    map_wdata = {1'b1, LW'(vcnt_q)};
    map_re    = 1'b0;
    map_raddr = AW'(cur_corner);
    tl_we     = 1'b0;
    tl_waddr  = LW'(vcnt_q);
    tl_re     = 1'b0;
    tl_raddr  = LW'(clr_q);
    case (state_q)
      S_INIT: begin
        map_we    = 1'b1;
        map_waddr = init_q;
        map_wdata = '0;
      end
      S_LOOK: begin
        map_re = (k_q != 2'd3);
      end
      S_CLEAR: begin
        tl_re     = clr_rd;
        map_we    = pend_q;
        map_waddr = tl_rdata;
        map_wdata = '0;
      end
      S_APPEND: begin
        map_we = !cur_dup && !cur_valid;
        tl_we  = !cur_dup && !cur_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      init_q   <= '0;
      k_q      <= '0;
      look_v_q <= '0;
      vcnt_q   <= '0;
      icnt_q   <= '0;
      err_q    <= 1'b0;
      clr_q    <= '0;
      pend_q   <= 1'b0;
      fin_q    <= 1'b0;
    end else begin
      case (state_q)
        S_INIT: begin
          init_q <= init_q + AW'(1);
          if (init_q == InitLast) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            res_q  <= res_init;
            k_q    <= '0;
            if (in_bad) begin
              err_q   <= 1'b1;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          // read issued at step k is captured at step k + 1
          if (k_q != 2'd0) begin
            look_v_q[k_q - 2'd1] <= map_rdata[LW];
            look_l_q[k_q - 2'd1] <= map_rdata[LW-1:0];
          end
          k_q <= k_q + 2'd1;
          if (k_q == 2'd3) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          k_q <= '0;
          if (need_close) begin
            res_q.starts_new_batch <= 1'b1;
            clr_q   <= '0;
            pend_q  <= 1'b0;
            fin_q   <= 1'b0;
            state_q <= S_CLEAR;
          end else begin
            state_q <= S_APPEND;
          end
        end
        S_CLEAR: begin
          pend_q <= clr_rd;
          if (clr_rd) begin
            clr_q <= clr_q + VCW'(1);
          end
          if (!clr_rd && !pend_q) begin
            vcnt_q   <= '0;
            icnt_q   <= '0;
            look_v_q <= '0;
            state_q  <= fin_q ? S_IDLE : S_APPEND;
          end
        end
        S_APPEND: begin
          case (k_q)
            2'd0:    res_q.local_a <= cur_local;
            2'd1:    res_q.local_b <= cur_local;
            default: res_q.local_c <= cur_local;
          endcase
          if (!cur_dup && !cur_valid) begin
            vcnt_q <= vcnt_q + VCW'(1);
            res_q.appended_count <= res_q.appended_count + 2'd1;
            case (res_q.appended_count)
              2'd0:    res_q.appended_first  <= cur_corner;
              2'd1:    res_q.appended_second <= cur_corner;
              default: res_q.appended_third  <= cur_corner;
            endcase
          end
          k_q <= k_q + 2'd1;
          if (k_q == 2'd2) begin
            icnt_q           <= ICW'(idx_sum);
            res_q.error_flag <= err_q;
            state_q          <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ready_i) begin
            if (item_q.last_triangle) begin
              // mesh done: close the final batch and drop the error
              err_q  <= 1'b0;
              clr_q  <= '0;
              pend_q <= 1'b0;
              fin_q  <= 1'b1;
              state_q <= (vcnt_q != '0) ? S_CLEAR : S_IDLE;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign emit_valid_o = (state_q == S_EMIT);
  assign emit_data_o  = res_q;

  tbs_ram #(
    .WIDTH (DW),
    .DEPTH (SOURCE_VERTICES)
  ) u_remap (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  tbs_ram #(
    .WIDTH (AW),
    .DEPTH (BATCH_VERTICES)
  ) u_touched (
    .clk_i   (clk_i),
    .we_i    (tl_we),
    .waddr_i (tl_waddr),
    .wdata_i (AW'(cur_corner)),
    .re_i    (tl_re),
    .raddr_i (tl_raddr),
    .rdata_o (tl_rdata)
  );

endmodule

[hdl/triangle_batch_splitter_core.sv]
// Channel   Signals                                   Beat moves
// in        in_valid_i / in_ready_o / in_data_i        one triangle (three corners, last flag)
// out       out_valid_o / out_ready_i / out_data_o     one result (locals, appended list, flags)
// cfg       cfg_we_i / cfg_index_i / cfg_data_i        one register write, no wait
//
// A triangle goes through accept, four remap RAM steps (three reads, one
// capture), a limit check, three append steps, and the result beat.
// Closing a batch walks the touched list through the single remap write
// port; a last triangle closes after its beat. After reset the remap RAM
// is swept once, clearing every entry, with in_ready_o low. The result
// register holds one result while out stalls; the sequencer goes on to its next result beat.
module triangle_batch_splitter_core #(
  parameter int unsigned SOURCE_VERTICES = 65536,
  parameter int unsigned BATCH_VERTICES  = 1024,
  parameter int unsigned BATCH_INDICES   = 3072
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tbs_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tbs_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tbs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tbs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  tbs_pkg::lim_t  lim;
  tbs_pkg::out_t  emit_data;
  logic           emit_valid;
  logic           slot_free;
  logic           out_valid_q;
  tbs_pkg::out_t  out_q;

  assign slot_free = !out_valid_q || out_ready_i;

  tbs_cfg #(
    .SOURCE_VERTICES (SOURCE_VERTICES),
    .BATCH_VERTICES  (BATCH_VERTICES),
    .BATCH_INDICES   (BATCH_INDICES)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .lim_o       (lim)
  );

  tbs_seq #(
    .SOURCE_VERTICES (SOURCE_VERTICES),
    .BATCH_VERTICES  (BATCH_VERTICES),
    .BATCH_INDICES   (BATCH_INDICES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lim_i        (lim),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .emit_valid_o (emit_valid),
    .emit_ready_i (slot_free),
    .emit_data_o  (emit_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_valid && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid && slot_free) begin
      out_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
